FILE: rtl/bct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bct_pkg: shared types and constants for the box corner transform
// Matrix entry type, queue entry type, register indexes, saturation and rounding helpers.
// ----------------------------------------------------------------------------
package bct_pkg;

    localparam int unsigned ENTRY_W = 32;   // Q27 entry, clamped to +-2^30

    localparam logic [2:0] REG_TX = 3'd0;
    localparam logic [2:0] REG_TY = 3'd1;
    localparam logic [2:0] REG_TZ = 3'd2;
    localparam logic [2:0] REG_QW = 3'd3;
    localparam logic [2:0] REG_QX = 3'd4;
    localparam logic [2:0] REG_QY = 3'd5;
    localparam logic [2:0] REG_QZ = 3'd6;

    typedef logic signed [ENTRY_W-1:0] entry_t;
    typedef entry_t mat_t [9];

    // one object after the front end: pose matrix, centre, sizes
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic        [30:0] size_x;
        logic        [30:0] size_y;
        logic        [30:0] size_z;
        logic signed [ENTRY_W-1:0] m0, m1, m2, m3, m4, m5, m6, m7, m8;
    } obj_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // round half away from zero, divide by 2^k
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] s,
                                                     input int unsigned k);
        logic [63:0] a;
        logic [63:0] h;
        h = 64'd1 << (k - 1);
        a = s[63] ? 64'(-s) : 64'(s);
        a = (a + h) >> k;
        return s[63] ? -$signed(a) : $signed(a);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/bct_quat.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bct_quat: quaternion to rotation matrix
// Two registered stages: nine products, then the entry sums and clamp.
// ----------------------------------------------------------------------------
module bct_quat (
    input  wire                 aclk,
    input  wire                 en,
    input  wire signed [15:0]   qw,
    input  wire signed [15:0]   qx,
    input  wire signed [15:0]   qy,
    input  wire signed [15:0]   qz,
    output bct_pkg::mat_t       m
);
    import bct_pkg::*;

    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [31:0] xw_reg, yw_reg, zw_reg;
    mat_t m_reg;

    function automatic entry_t clampe(input logic signed [33:0] e);
        if (e > 34'sd1073741824) return 32'sd1073741824;
        if (e < -34'sd1073741824) return -32'sd1073741824;
        return e[31:0];
    endfunction

    localparam logic signed [33:0] ONE = 34'sd134217728;

    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg <= qx * qx; yy_reg <= qy * qy; zz_reg <= qz * qz;
            xy_reg <= qx * qy; xz_reg <= qx * qz; yz_reg <= qy * qz;
            xw_reg <= qx * qw; yw_reg <= qy * qw; zw_reg <= qz * qw;
            m_reg[0] <= clampe(ONE - (34'(yy_reg) + 34'(zz_reg)));
            m_reg[1] <= clampe(34'(xy_reg) - 34'(zw_reg));
            m_reg[2] <= clampe(34'(xz_reg) + 34'(yw_reg));
            m_reg[3] <= clampe(34'(xy_reg) + 34'(zw_reg));
            m_reg[4] <= clampe(ONE - (34'(xx_reg) + 34'(zz_reg)));
            m_reg[5] <= clampe(34'(yz_reg) - 34'(xw_reg));
            m_reg[6] <= clampe(34'(xz_reg) - 34'(yw_reg));
            m_reg[7] <= clampe(34'(yz_reg) + 34'(xw_reg));
            m_reg[8] <= clampe(ONE - (34'(xx_reg) + 34'(yy_reg)));
        end
    end

    assign m = m_reg;
endmodule
`default_nettype wire

FILE: rtl/bct_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bct_front: input stage
// Accepts an object, builds its pose matrix through the quaternion unit, pushes to queue.
// ----------------------------------------------------------------------------
module bct_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [287:0]        s_tdata,
    output logic                q_push,
    output bct_pkg::obj_t       q_obj,
    input  wire                 q_space   // queue can take one push now
);
    import bct_pkg::*;

    logic [1:0] vld_reg;
    logic [287:0] d1_reg, d2_reg;
    mat_t pm;
    logic adv;

    // pipe advances whenever its tail can drain
    assign adv      = !vld_reg[1] || q_space;
    assign s_tready = adv;
    assign q_push   = vld_reg[1] && q_space;

    bct_quat u_quat (
        .aclk(aclk), .en(adv),
        .qw(s_tdata[111:96]), .qx(s_tdata[127:112]),
        .qy(s_tdata[143:128]), .qz(s_tdata[159:144]),
        .m(pm)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[0], s_tvalid};
        end
        if (adv) begin
            d1_reg <= s_tdata;
            d2_reg <= d1_reg;
        end
    end

    always_comb begin
        q_obj.pos_x  = d2_reg[31:0];
        q_obj.pos_y  = d2_reg[63:32];
        q_obj.pos_z  = d2_reg[95:64];
        q_obj.size_x = d2_reg[190:160];
        q_obj.size_y = d2_reg[221:191];
        q_obj.size_z = d2_reg[252:222];
        q_obj.m0 = pm[0]; q_obj.m1 = pm[1]; q_obj.m2 = pm[2];
        q_obj.m3 = pm[3]; q_obj.m4 = pm[4]; q_obj.m5 = pm[5];
        q_obj.m6 = pm[6]; q_obj.m7 = pm[7]; q_obj.m8 = pm[8];
    end
endmodule
`default_nettype wire

FILE: rtl/bct_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bct_fifo: two-entry queue between front and back
// Register based; a push into a full queue only comes with a pop.
// ----------------------------------------------------------------------------
module bct_fifo (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  bct_pkg::obj_t       din,
    output logic                full,
    input  wire                 pop,
    output logic                empty,
    output bct_pkg::obj_t       dout
);
    import bct_pkg::*;

    obj_t mem_reg [2];
    logic rd_reg, wr_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign dout  = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg <= 1'b0; wr_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= !wr_reg;
            if (pop)  rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
        if (push) mem_reg[wr_reg] <= din;
    end

    assert property (@(posedge aclk) disable iff (!aresetn) !(push && full && !pop))
        else $error("queue overflow");
    assert property (@(posedge aclk) disable iff (!aresetn) !(pop && empty))
        else $error("queue underflow");
    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue count out of range");
endmodule
`default_nettype wire

FILE: rtl/bct_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bct_back: corner generator
// Walks eight corners of the head object through a five-stage pipe:
// pose products, pose sum/round, ext products, ext sum/round, output.
// ----------------------------------------------------------------------------
module bct_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 q_empty,
    input  bct_pkg::obj_t       q_obj,
    output logic                q_pop,
    input  bct_pkg::mat_t       em,
    input  wire signed [31:0]   ext_tx,
    input  wire signed [31:0]   ext_ty,
    input  wire signed [31:0]   ext_tz,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [103:0]        m_tdata,
    output logic                m_tlast
);
    import bct_pkg::*;

    logic [2:0] k_reg;
    logic [3:0] v_reg;                  // stage valids
    logic [2:0] i1_reg, i2_reg, i3_reg, i4_reg;
    logic signed [63:0] pp_reg [9];
    logic signed [31:0] t1_reg [3];
    logic signed [31:0] p1_reg [3];
    logic signed [63:0] ep_reg [9];
    logic signed [31:0] oc_reg [3];
    logic signed [31:0] oc0_reg [3];
    logic [2:0] oi_reg;
    logic ov_reg;
    logic adv, issue;
    logic signed [31:0] hv [3];
    logic signed [31:0] em32 [9];
    logic signed [31:0] pm32 [9];

    assign adv   = !ov_reg || m_tready;
    assign issue = adv && !q_empty;
    assign q_pop = issue && k_reg == 3'd7;

    always_comb begin
        pm32[0] = q_obj.m0; pm32[1] = q_obj.m1; pm32[2] = q_obj.m2;
        pm32[3] = q_obj.m3; pm32[4] = q_obj.m4; pm32[5] = q_obj.m5;
        pm32[6] = q_obj.m6; pm32[7] = q_obj.m7; pm32[8] = q_obj.m8;
        for (int i = 0; i < 9; i++) em32[i] = em[i];
        hv[0] = (k_reg[0] ^ k_reg[1]) ? $signed({1'b0, q_obj.size_x})
                                       : -$signed({1'b0, q_obj.size_x});
        hv[1] = k_reg[1] ? $signed({1'b0, q_obj.size_y}) : -$signed({1'b0, q_obj.size_y});
        hv[2] = k_reg[2] ? $signed({1'b0, q_obj.size_z}) : -$signed({1'b0, q_obj.size_z});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= '0; v_reg <= '0; ov_reg <= 1'b0;
        end else if (adv) begin
            if (issue) k_reg <= k_reg + 3'd1;
            v_reg  <= {v_reg[2:0], issue};
            ov_reg <= v_reg[3];
        end
        if (adv) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    pp_reg[3*r+c] <= 64'(pm32[3*r+c]) * 64'(hv[c]);
            t1_reg[0] <= q_obj.pos_x; t1_reg[1] <= q_obj.pos_y; t1_reg[2] <= q_obj.pos_z;
            i1_reg <= k_reg;
            for (int r = 0; r < 3; r++)
                p1_reg[r] <= sat32(rnd_shift(pp_reg[3*r] + pp_reg[3*r+1] + pp_reg[3*r+2],
                                             28) + 64'(t1_reg[r]));
            i2_reg <= i1_reg;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    ep_reg[3*r+c] <= 64'(em32[3*r+c]) * 64'(p1_reg[c]);
            i3_reg <= i2_reg;
            oc0_reg[0] <= sat32(rnd_shift(ep_reg[0] + ep_reg[1] + ep_reg[2], 27)
                                + 64'(ext_tx));
            oc0_reg[1] <= sat32(rnd_shift(ep_reg[3] + ep_reg[4] + ep_reg[5], 27)
                                + 64'(ext_ty));
            oc0_reg[2] <= sat32(rnd_shift(ep_reg[6] + ep_reg[7] + ep_reg[8], 27)
                                + 64'(ext_tz));
            i4_reg <= i3_reg;
            oc_reg <= oc0_reg;
            oi_reg <= i4_reg;
        end
    end

    assign m_tvalid = ov_reg;
    // corner_x, corner_y, corner_z, corner_index, 5 pad bits
    assign m_tdata  = {5'b0, oi_reg, oc_reg[2], oc_reg[1], oc_reg[0]};
    assign m_tlast  = oi_reg == 3'd7;

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> k_reg == 3'd7) else $error("pop mid object");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(oc_reg[0]) && $stable(oi_reg))
        else $error("output changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> $past(oi_reg) != 3'd7)
        else $error("corner order broken");
endmodule
`default_nettype wire

FILE: rtl/box_corner_transform.sv
`default_nettype none
// An accepted input word passes 2 front stages, a queue write and 5 back stages
// on its way to the first corner word on m_tdata.
// The corner walker emits one corner word per cycle unless stalled by m_tready
// or an empty queue, eight words per object.
// Reset (aresetn, synchronous, active low) empties pipes and queue, sets the
// extrinsic to identity: zero translation, quaternion w = 1.0.
// ----------------------------------------------------------------------------
// box_corner_transform: oriented box corners through pose and extrinsic
// Front builds pose matrix, queue decouples, back emits eight corners.
// ----------------------------------------------------------------------------
module box_corner_transform (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, orient_w, orient_x, orient_y, orient_z,
    // size_x, size_y, size_z, 3 pad bits
    input  wire  [255:0] s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // corner_x, corner_y, corner_z, corner_index, 5 pad bits
    output logic [103:0] m_tdata,
    output logic         m_tlast,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [4:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import bct_pkg::*;

    logic signed [31:0] tx_reg, ty_reg, tz_reg;
    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic wr;
    logic [2:0] ridx;
    logic q_push, q_pop, q_full, q_empty;
    obj_t q_in, q_out;
    mat_t em;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign ridx   = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_reg <= '0; ty_reg <= '0; tz_reg <= '0;
            qw_reg <= 16'sd16384; qx_reg <= '0; qy_reg <= '0; qz_reg <= '0;
        end else if (wr) begin
            unique case (ridx)
                REG_TX: tx_reg <= pwdata;
                REG_TY: ty_reg <= pwdata;
                REG_TZ: tz_reg <= pwdata;
                REG_QW: qw_reg <= pwdata[15:0];
                REG_QX: qx_reg <= pwdata[15:0];
                REG_QY: qy_reg <= pwdata[15:0];
                REG_QZ: qz_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            REG_TX: prdata = tx_reg;
            REG_TY: prdata = ty_reg;
            REG_TZ: prdata = tz_reg;
            REG_QW: prdata = 32'(qw_reg);
            REG_QX: prdata = 32'(qx_reg);
            REG_QY: prdata = 32'(qy_reg);
            REG_QZ: prdata = 32'(qz_reg);
            default: prdata = '0;
        endcase
    end

    // extrinsic matrix follows registers; static only while they are not written
    bct_quat u_equat (
        .aclk(aclk), .en(1'b1),
        .qw(qw_reg), .qx(qx_reg), .qy(qy_reg), .qz(qz_reg), .m(em)
    );

    bct_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata({32'b0, s_tdata}),
        .q_push(q_push), .q_obj(q_in),
        .q_space(!q_full || q_pop)
    );

    bct_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .din(q_in), .full(q_full),
        .pop(q_pop), .empty(q_empty), .dout(q_out)
    );

    bct_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_empty(q_empty), .q_obj(q_out), .q_pop(q_pop),
        .em(em), .ext_tx(tx_reg), .ext_ty(ty_reg), .ext_tz(tz_reg),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast)
    );
endmodule
`default_nettype wire
